### rtl/radix_text_to_word_parser_assert.svh
// Assertion macros shared by the parser checker.
`ifndef RADIX_TEXT_TO_WORD_PARSER_ASSERT_SVH
`define RADIX_TEXT_TO_WORD_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define RTWP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("parser check failed");

// Next-cycle implication, disabled while in reset.
`define RTWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

### rtl/rtwp_pkg.sv
package rtwp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_NUMBER = 2'd1,
    PH_HALTED = 2'd2
  } phase_e;

  // Radix codes; any other code behaves as hexadecimal
  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  localparam logic [5:0] CAP_BIN = 6'd32;
  localparam logic [5:0] CAP_OCT = 6'd11;
  localparam logic [5:0] CAP_HEX = 6'd8;

  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_7   = 8'h37;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef struct packed {
    logic       is_digit;  // valid digit for the current radix
    logic [3:0] value;     // digit value when is_digit
    logic       starter;   // 0-9 or a-f
    logic       stop;      // NUL or byte of 128 and above
    logic [5:0] cap;       // digit cap for the current radix
  } dec_t;

endpackage

### rtl/radix_text_to_word_parser.sv
// Parses a stream of ASCII bytes into 32-bit words in radix 2, 8 or 16, chosen by
// cfg_wdata_i (0 binary, 1 octal, 2 or 3 hexadecimal, reset hexadecimal). One byte is
// taken every cycle while no word is held at a stalled output. A byte goes through an
// input register, and its word, if any, is then loaded into the output register that
// drives out_valid_o. The accumulator and digit count are updated as each byte is
// taken, so parsing a number does not slow the byte stream. A word is produced when a
// number ends on a non-digit, when the digit cap is hit (32, 11 or 8 digits), for a
// starter byte not valid in the radix (word 0), or on end_of_input_i inside a number.
// NUL or a byte of 128 and above outside a number stops parsing until end_of_input_i.
// Change the radix only while no word is in flight.
module radix_text_to_word_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] word_value_o
);
  import rtwp_pkg::*;

  logic [1:0] radix_q;
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q, s1_byte_d;
  logic       s1_end_q, s1_end_d;
  logic       take;
  logic       in_accept;
  dec_t       dec;

  assign in_stall_o = s1_valid_q && !take;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q && !take;
    s1_byte_d  = s1_byte_q;
    s1_end_d   = s1_end_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
      s1_byte_d  = text_byte_i;
      s1_end_d   = end_of_input_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RADIX_HEX;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_byte_q <= s1_byte_d;
    s1_end_q  <= s1_end_d;
  end

  rtwp_digit_decode u_decode (
    .text_byte_i (s1_byte_q),
    .radix_i     (radix_q),
    .dec_o       (dec)
  );

  rtwp_parse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s1_valid_q),
    .item_end_i   (s1_end_q),
    .dec_i        (dec),
    .radix_i      (radix_q),
    .out_stall_i  (out_stall_i),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .word_value_o (word_value_o)
  );

endmodule

### rtl/rtwp_digit_decode.sv
module rtwp_digit_decode (
  input  logic [7:0]     text_byte_i,
  input  logic [1:0]     radix_i,
  output rtwp_pkg::dec_t dec_o
);
  import rtwp_pkg::*;

  logic is_dec;
  logic is_hex_letter;

  always_comb begin
    is_dec        = (text_byte_i inside {[CH_0:CH_9]});
    is_hex_letter = (text_byte_i inside {[CH_A:CH_F]});

    dec_o.starter = is_dec || is_hex_letter;
    dec_o.stop    = (text_byte_i == CH_NUL) || text_byte_i[7];
    // 'a' has low nibble 1, so add 9 to land on 10
    dec_o.value   = is_hex_letter ? 4'(text_byte_i[3:0] + 4'd9) : text_byte_i[3:0];

    case (radix_i)
      RADIX_BIN: begin
        dec_o.is_digit = (text_byte_i inside {[CH_0:CH_1]});
        dec_o.cap      = CAP_BIN;
      end
      RADIX_OCT: begin
        dec_o.is_digit = (text_byte_i inside {[CH_0:CH_7]});
        dec_o.cap      = CAP_OCT;
      end
      default: begin
        dec_o.is_digit = is_dec || is_hex_letter;
        dec_o.cap      = CAP_HEX;
      end
    endcase
  end

endmodule

### rtl/rtwp_parse_core.sv
module rtwp_parse_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  logic           item_end_i,
  input  rtwp_pkg::dec_t dec_i,
  input  logic [1:0]     radix_i,
  input  logic           out_stall_i,
  output logic           take_o,
  output logic           out_valid_o,
  output logic [31:0]    word_value_o
);
  import rtwp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] acc_q, acc_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] word_q, word_d;

  logic [31:0] acc_shift;
  logic [5:0]  cnt_inc;
  logic        emit;
  logic [31:0] emit_value;

  // Result register is free when empty or being taken
  assign take_o = item_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (radix_i)
      RADIX_BIN: acc_shift = {acc_q[30:0], dec_i.value[0]};
      RADIX_OCT: acc_shift = {acc_q[28:0], dec_i.value[2:0]};
      default:   acc_shift = {acc_q[27:0], dec_i.value};
    endcase
    cnt_inc = 6'(cnt_q + 6'd1);
  end

  // Next state
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    if (take_o) begin
      if (item_end_i) begin
        phase_d = PH_IDLE;
        acc_d   = '0;
        cnt_d   = '0;
      end else begin
        case (phase_q)
          PH_HALTED: begin
            phase_d = PH_HALTED;
          end
          PH_NUMBER: begin
            if (dec_i.is_digit && (cnt_inc < dec_i.cap)) begin
              acc_d = acc_shift;
              cnt_d = cnt_inc;
            end else begin
              phase_d = PH_IDLE;
              acc_d   = '0;
              cnt_d   = '0;
            end
          end
          default: begin
            if (dec_i.stop) begin
              phase_d = PH_HALTED;
            end else if (dec_i.starter && dec_i.is_digit) begin
              phase_d = PH_NUMBER;
              acc_d   = 32'(dec_i.value);
              cnt_d   = 6'd1;
            end else if (dec_i.starter) begin
              phase_d = PH_IDLE;
              acc_d   = '0;
              cnt_d   = '0;
            end
          end
        endcase
      end
    end
  end

  // Result generation
  always_comb begin
    emit       = 1'b0;
    emit_value = acc_q;
    if (item_end_i) begin
      emit = (phase_q == PH_NUMBER);
    end else begin
      case (phase_q)
        PH_HALTED: begin
          emit = 1'b0;
        end
        PH_NUMBER: begin
          emit = 1'b1;
          if (dec_i.is_digit) begin
            emit       = (cnt_inc >= dec_i.cap);
            emit_value = acc_shift;
          end
        end
        default: begin
          // out-of-radix starter gives a zero word
          emit       = !dec_i.stop && dec_i.starter && !dec_i.is_digit;
          emit_value = '0;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    word_d      = word_q;
    if (take_o) begin
      out_valid_d = emit;
      if (emit) begin
        word_d = emit_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o  = out_valid_q;
  assign word_value_o = word_q;

endmodule

### rtl/rtwp_checker.sv
`include "radix_text_to_word_parser_assert.svh"

module rtwp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] word_value_o
);

  logic in_take;

  assign in_take = in_valid_i && !in_stall_o;

  // Input back-pressure only comes from a word held at a stalled output
  `RTWP_ASSERT_IMPL(a_stall_from_out, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // No word appears without a byte taken beforehand through the input register
  `RTWP_ASSERT_NEXT(a_no_spurious, clk_i, rst_ni, !out_valid_o && !$past(in_take), !out_valid_o)

  // Held word stays valid and unchanged
  `RTWP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `RTWP_ASSERT_NEXT(a_word_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(word_value_o))

endmodule

bind radix_text_to_word_parser rtwp_checker u_rtwp_checker (.*);
